FILE: rtl/krt_pkg.sv
// Shared constants, codes and record types for the keyed record table.
package krt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 10;
    localparam int POS_W    = 6;
    localparam int ECNT_W   = 7;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    // floor(x / 3) for x <= 765 as (x * 683) >> 11
    localparam int MEAN_MUL   = 683;
    localparam int MEAN_SHIFT = 11;
    localparam int PROD_W     = SUM_W + MEAN_SHIFT;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_LOOKUP     = 2'd2,
        OP_LOOKUP_ALT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_DUP  = 2'd2,
        STAT_MISS = 2'd3
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] mean;
        logic [BYTE_W-1:0] g3;
        logic [BYTE_W-1:0] g2;
        logic [BYTE_W-1:0] g1;
        logic [BYTE_W-1:0] att;
        logic [KEY_W-1:0]  key;
    } t_rec;

    typedef struct packed {
        logic [BYTE_W-1:0] mean_out;
        logic [BYTE_W-1:0] grade_c_out;
        logic [BYTE_W-1:0] grade_b_out;
        logic [BYTE_W-1:0] grade_a_out;
        logic [BYTE_W-1:0] attendance_out;
        logic [ECNT_W-1:0] entry_count;
        logic [POS_W-1:0]  position;
        t_stat             status;
    } t_res;

    function automatic logic [BYTE_W-1:0] mean3(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(MEAN_MUL);
        return prod[MEAN_SHIFT +: BYTE_W];
    endfunction

endpackage

FILE: rtl/keyed_record_table.sv
// Keyed record table: packed record memory with linear search and shift-down removal.
//
//  channel | dir | handshake                         | payload
//  --------+-----+-----------------------------------+-------------------------------------
//  s_axis  | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: key, attendance, grades 1..3
//          |     |                                   | tuser: opcode
//  m_axis  | out | o_m_axis_tvalid / i_m_axis_tready | tdata: status, position, count,
//          |     |                                   |        attendance, grades, mean
//
// Flow: one word at a time; a search reads one entry a cycle from the registered read port.
// A miss, an append or a remove scans every entry before its result is ready, a hit stops
// at the matching entry, and an insert into a full table is refused without a search.
// A remove moves later entries down as they stream past, so it ends with the scan.
// Reset clears the fill count and all control; memory contents are left as they are.
// A result waits in the output register; the next word can be taken once it is loaded there.
module keyed_record_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // key[31:0], attendance_in[39:32], grade_first[47:40], grade_second[55:48],
    // grade_third[63:56]
    input  logic [krt_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[1:0]
    input  logic [krt_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[1:0], position[7:2], entry_count[14:8], attendance_out[22:15],
    // grade_a_out[30:23], grade_b_out[38:31], grade_c_out[46:39], mean_out[54:47], zero[55]
    output logic [krt_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);
    import krt_pkg::*;

    // Record memory: one write and one registered read port
    t_rec             r_mem [CAPACITY];
    t_rec             r_rd_data;
    logic             w_re;
    logic [IDX_W-1:0] w_ra;
    logic             w_we;
    logic [IDX_W-1:0] w_wa;
    t_rec             w_wd;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    t_rec             r_req, n_req;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    t_res             r_res, n_res;
    logic             r_out_vld, n_out_vld;
    t_res             r_out, n_out;

    logic             w_s_fire;
    logic             w_m_fire;
    logic             w_issue;
    logic             w_match;
    logic             w_full;
    logic [SUM_W-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_fire        = r_out_vld && i_m_axis_tready;
    assign w_full          = (r_fill == CNT_W'(CAPACITY));

    // Read one entry per cycle while searching or shifting, stop at the fill mark
    assign w_issue = ((r_state == S_SEARCH) || (r_state == S_SHIFT)) && (r_addr < r_fill);
    assign w_re    = w_issue;
    assign w_ra    = r_addr[IDX_W-1:0];
    assign w_match = r_rd_vld && (r_rd_data.key == r_req.key);

    assign w_sum = SUM_W'(i_s_axis_tdata[47:40]) + SUM_W'(i_s_axis_tdata[55:48])
                 + SUM_W'(i_s_axis_tdata[63:56]);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_req     = r_req;
        n_fill    = r_fill;
        n_addr    = r_addr + CNT_W'(w_issue);
        n_rd_vld  = w_issue;
        n_rd_idx  = r_addr[IDX_W-1:0];
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !w_m_fire;
        w_we      = 1'b0;
        w_wa      = r_fill[IDX_W-1:0];
        w_wd      = r_req;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    n_op       = t_op'(i_s_axis_tuser[1:0]);
                    n_req.key  = i_s_axis_tdata[31:0];
                    n_req.att  = i_s_axis_tdata[39:32];
                    n_req.g1   = i_s_axis_tdata[47:40];
                    n_req.g2   = i_s_axis_tdata[55:48];
                    n_req.g3   = i_s_axis_tdata[63:56];
                    n_req.mean = mean3(w_sum);
                    n_addr     = '0;
                    n_res      = '0;
                    n_res.entry_count = ECNT_W'(r_fill);
                    // Refuse an insert into a full table before any search
                    if ((t_op'(i_s_axis_tuser[1:0]) == OP_INSERT) && w_full) begin
                        n_res.status = STAT_FULL;
                        n_state      = S_FINISH;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_match) begin
                    case (r_op)
                        OP_INSERT: begin
                            n_res.status = STAT_DUP;
                            n_state      = S_FINISH;
                        end
                        OP_REMOVE: begin
                            // Later entries follow one a cycle; the next read is in flight
                            n_res.status      = STAT_OK;
                            n_res.position    = POS_W'(r_rd_idx);
                            n_res.entry_count = ECNT_W'(r_fill - 1'b1);
                            n_state           = S_SHIFT;
                        end
                        default: begin
                            n_res.status         = STAT_OK;
                            n_res.position       = POS_W'(r_rd_idx);
                            n_res.attendance_out = r_rd_data.att;
                            n_res.grade_a_out    = r_rd_data.g1;
                            n_res.grade_b_out    = r_rd_data.g2;
                            n_res.grade_c_out    = r_rd_data.g3;
                            n_res.mean_out       = r_rd_data.mean;
                            n_state              = S_FINISH;
                        end
                    endcase
                end else if (!r_rd_vld && !w_issue) begin
                    // Search exhausted: append on insert, report a miss otherwise
                    if (r_op == OP_INSERT) begin
                        w_we              = 1'b1;
                        n_fill            = r_fill + 1'b1;
                        n_res.status      = STAT_OK;
                        n_res.position    = POS_W'(r_fill);
                        n_res.entry_count = ECNT_W'(r_fill + 1'b1);
                    end else begin
                        n_res.status = STAT_MISS;
                    end
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                // Move each entry read back down by one place
                if (r_rd_vld) begin
                    w_we = 1'b1;
                    w_wa = r_rd_idx - 1'b1;
                    w_wd = r_rd_data;
                end else if (!w_issue) begin
                    n_fill  = r_fill - 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(M_TDATA_W - $bits(t_res)){1'b0}}, r_out};

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("memory write while idle");

    a_fail_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status != STAT_OK)) |-> (r_out.position == '0)
            && (r_out.attendance_out == '0) && (r_out.mean_out == '0))
        else $error("refused operation reports record data");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> (r_state != S_IDLE))
        else $error("accepted word did not start an operation");
`endif

endmodule

FILE: test/tb_keyed_record_table.sv
// Self-checking testbench for keyed_record_table: directed and random stream traffic.
module tb_keyed_record_table;

    import krt_pkg::*;

    localparam int POOL_SIZE = 96;

    // Expected-reply store plus a shadow copy of the record table.
    class record_table_model;
        logic [KEY_W-1:0]  keys [CAPACITY];
        logic [BYTE_W-1:0] atts [CAPACITY];
        logic [BYTE_W-1:0] ga [CAPACITY];
        logic [BYTE_W-1:0] gb [CAPACITY];
        logic [BYTE_W-1:0] gc [CAPACITY];
        logic [BYTE_W-1:0] means [CAPACITY];
        int                fill;
        t_res              pending_replies[$];
        int                mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Work out the reply to one accepted word and update the shadow table.
        function void note_request(t_op op, logic [KEY_W-1:0] key, logic [BYTE_W-1:0] att,
                                   logic [BYTE_W-1:0] g1, logic [BYTE_W-1:0] g2,
                                   logic [BYTE_W-1:0] g3);
            t_res r;
            int   hit;
            int   i;
            r   = '0;
            hit = fill;
            for (i = fill - 1; i >= 0; i--) begin
                if (keys[i] == key) hit = i;
            end
            r.status = STAT_OK;
            case (op)
                OP_INSERT: begin
                    if (fill >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else if (hit < fill) begin
                        r.status = STAT_DUP;
                    end else begin
                        keys[fill]  = key;
                        atts[fill]  = att;
                        ga[fill]    = g1;
                        gb[fill]    = g2;
                        gc[fill]    = g3;
                        means[fill] = BYTE_W'((SUM_W'(g1) + SUM_W'(g2) + SUM_W'(g3)) / 3);
                        r.position  = POS_W'(fill);
                        fill++;
                    end
                end
                OP_REMOVE: begin
                    if (hit >= fill) begin
                        r.status = STAT_MISS;
                    end else begin
                        // close the gap: every later entry moves down by one
                        for (i = hit; i + 1 < fill; i++) begin
                            keys[i]  = keys[i+1];
                            atts[i]  = atts[i+1];
                            ga[i]    = ga[i+1];
                            gb[i]    = gb[i+1];
                            gc[i]    = gc[i+1];
                            means[i] = means[i+1];
                        end
                        fill--;
                        r.position = POS_W'(hit);
                    end
                end
                default: begin
                    if (hit >= fill) begin
                        r.status = STAT_MISS;
                    end else begin
                        r.position       = POS_W'(hit);
                        r.attendance_out = atts[hit];
                        r.grade_a_out    = ga[hit];
                        r.grade_b_out    = gb[hit];
                        r.grade_c_out    = gc[hit];
                        r.mean_out       = means[hit];
                    end
                end
            endcase
            r.entry_count = ECNT_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned seen);
            mismatches++;
            if (mismatches <= 10)
                $display("%t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                         want, seen);
        endfunction

        // Compare one accepted output word with the oldest expectation.
        function void check_reply(logic [M_TDATA_W-1:0] word);
            t_res want;
            t_res seen;
            if (pending_replies.size() == 0) begin
                flag("unexpected word", 0, word);
                return;
            end
            want = pending_replies.pop_front();
            seen = t_res'(word[$bits(t_res)-1:0]);
            if (seen.status !== want.status) flag("status", want.status, seen.status);
            if (seen.position !== want.position) flag("position", want.position, seen.position);
            if (seen.entry_count !== want.entry_count)
                flag("entry_count", want.entry_count, seen.entry_count);
            if (seen.attendance_out !== want.attendance_out)
                flag("attendance_out", want.attendance_out, seen.attendance_out);
            if (seen.grade_a_out !== want.grade_a_out)
                flag("grade_a_out", want.grade_a_out, seen.grade_a_out);
            if (seen.grade_b_out !== want.grade_b_out)
                flag("grade_b_out", want.grade_b_out, seen.grade_b_out);
            if (seen.grade_c_out !== want.grade_c_out)
                flag("grade_c_out", want.grade_c_out, seen.grade_c_out);
            if (seen.mean_out !== want.mean_out) flag("mean_out", want.mean_out, seen.mean_out);
            if (word[M_TDATA_W-1:$bits(t_res)] !== '0)
                flag("padding", 0, word[M_TDATA_W-1:$bits(t_res)]);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata;
    logic [S_TUSER_W-1:0]   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;

    record_table_model      table_model;
    logic [KEY_W-1:0]       key_pool [POOL_SIZE];
    bit                     stalls_on;

    keyed_record_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // generous bound: well above the slowest legal run
    initial begin
        #20_000_000;
        $display("keyed_record_table regression: fail");
        $finish;
    end

    // Receiver: mostly ready, with random stall bursts while stalls are enabled.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 11) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            table_model.check_reply(o_m_axis_tdata);
    end

    // Present one word from a falling edge and hold it until accepted.
    task automatic send_word(t_op op, logic [KEY_W-1:0] key, logic [BYTE_W-1:0] att,
                             logic [BYTE_W-1:0] g1, logic [BYTE_W-1:0] g2,
                             logic [BYTE_W-1:0] g3);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {g3, g2, g1, att, key};
        do @(posedge i_clk); while (!o_s_axis_tready);
        table_model.note_request(op, key, att, g1, g2, g3);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (table_model.pending_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_grade();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Random words; weights steer the table towards filling, draining or churning.
    task automatic run_random(int count, int ins_w, int rem_w);
        int               n;
        int               r;
        t_op              op;
        logic [KEY_W-1:0] key;
        for (n = 0; n < count; n++) begin
            if (stalls_on && $urandom_range(0, 9) == 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < ins_w)
                op = OP_INSERT;
            else if (r < ins_w + rem_w)
                op = OP_REMOVE;
            else if ($urandom_range(0, 3) == 0)
                op = OP_LOOKUP_ALT;
            else
                op = OP_LOOKUP;
            if ($urandom_range(0, 99) < 5)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_word(op, key, BYTE_W'($urandom_range(0, 255)), pick_grade(), pick_grade(),
                      pick_grade());
        end
    endtask

    initial begin
        int i;
        table_model     = new();
        stalls_on       = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_INSERT;
        key_pool[0]     = '0;
        key_pool[1]     = '1;
        for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table, field extremes, duplicates, misses, head/middle/tail removal.
        send_word(OP_LOOKUP, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_REMOVE, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_INSERT, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_INSERT, 32'h0000_0000, 8'h11, 8'h22, 8'h33, 8'h44);
        send_word(OP_INSERT, 32'h1234_5678, 8'hA5, 8'h01, 8'h02, 8'h03);
        send_word(OP_INSERT, 32'h8000_0001, 8'h5A, 8'hFF, 8'h00, 8'h01);
        send_word(OP_INSERT, 32'h7FFF_FFFE, 8'h80, 8'hFE, 8'hFE, 8'hFE);
        send_word(OP_LOOKUP, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_LOOKUP_ALT, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_LOOKUP, 32'h8000_0001, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_LOOKUP, 32'h7FFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_REMOVE, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_REMOVE, 32'h7FFF_FFFE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_REMOVE, 32'h7FFF_FFFE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_REMOVE, 32'h1234_5678, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_LOOKUP_ALT, 32'h8000_0001, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_INSERT, 32'h0000_0000, 8'h7F, 8'h10, 8'h20, 8'h31);
        send_word(OP_LOOKUP, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        // hold the sender until the block has answered everything
        wait_drained();

        // Random: fill towards full, churn, drain, refill past full, then churn.
        stalls_on = 1'b1;
        run_random(400, 75, 10);
        wait_drained();
        stalls_on = 1'b0;
        run_random(200, 40, 30);
        stalls_on = 1'b1;
        run_random(300, 40, 30);
        wait_drained();
        run_random(300, 10, 60);
        run_random(300, 80, 5);
        wait_drained();
        run_random(250, 35, 35);
        // closing stretch runs with no stalls on either side
        stalls_on = 1'b0;
        run_random(150, 40, 30);
        wait_drained();
        repeat (CAPACITY + 16) @(posedge i_clk);

        if (table_model.mismatches == 0 && table_model.pending_replies.size() == 0)
            $display("keyed_record_table regression: pass");
        else
            $display("keyed_record_table regression: fail");
        $finish;
    end

endmodule
